### rtl/tcfp_pkg.sv
`default_nettype none

package tcfp_pkg;

    localparam int unsigned DATA_LEN  = 9;
    localparam int unsigned DCNT_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_BYTE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNRELIABLE_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_START       = 3'd5;

    // outcome codes
    localparam logic [1:0] OUTCOME_GOOD       = 2'd0;
    localparam logic [1:0] OUTCOME_UNRELIABLE = 2'd1;
    localparam logic [1:0] OUTCOME_CRC_ERR    = 2'd2;

    localparam logic [8:0] YEAR_BASE = 9'd100;

    typedef struct packed {
        logic [7:0]  flag_byte;
        logic [7:0]  id_byte;
        logic [7:0]  end_byte;
        logic [7:0]  unreliable_mask;
        logic [15:0] crc_poly;
        logic [15:0] crc_start;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [7:0]  status_bits;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second_val;
        logic [7:0]  day_of_month;
        logic [7:0]  month_index;
        logic [8:0]  year_offset;
        logic [15:0] utc_correction;
    } result_t;

    // one byte of MSB-first CRC-16, unrolled over the eight bits
    function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/tcfp_cfg.sv
`default_nettype none

module tcfp_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [tcfp_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [tcfp_pkg::CFG_DAT_W-1:0]    cfg_data,
    output tcfp_pkg::cfg_t                         cfg
);
    import tcfp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte       <= 8'd126;
            cfg_reg.id_byte         <= 8'd0;
            cfg_reg.end_byte        <= 8'd0;
            cfg_reg.unreliable_mask <= 8'd0;
            cfg_reg.crc_poly        <= 16'h1021;
            cfg_reg.crc_start       <= 16'hFFFF;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_FLAG_BYTE:       cfg_reg.flag_byte       <= cfg_data[7:0];
                REG_ID_BYTE:         cfg_reg.id_byte         <= cfg_data[7:0];
                REG_END_BYTE:        cfg_reg.end_byte        <= cfg_data[7:0];
                REG_UNRELIABLE_MASK: cfg_reg.unreliable_mask <= cfg_data[7:0];
                REG_CRC_POLY:        cfg_reg.crc_poly        <= cfg_data;
                REG_CRC_START:       cfg_reg.crc_start       <= cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/tcfp_parser.sv
`default_nettype none

module tcfp_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tcfp_pkg::cfg_t  cfg,
    input  wire logic            byte_valid,
    input  wire logic [7:0]      rx_byte,
    output logic                 res_valid,
    output tcfp_pkg::result_t    res
);
    import tcfp_pkg::*;

    localparam logic [2:0] PH_FLAG  = 3'd0;
    localparam logic [2:0] PH_ID    = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_CRC   = 3'd3;
    localparam logic [2:0] PH_FLAG2 = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    logic [2:0]        phase_reg, phase_next;
    logic [DCNT_W-1:0] count_reg, count_next;
    logic              crc_hi_reg, crc_hi_next;
    logic [15:0]       rx_crc_reg, rx_crc_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        data_reg [DATA_LEN];
    logic              data_we;
    logic [15:0]       crc_upd;
    logic              end_hit;

    // CRC of the incoming byte, seeded from start value on the ID byte
    assign crc_upd = crc_feed((phase_reg == PH_ID) ? cfg.crc_start : crc_reg,
                              rx_byte, cfg.crc_poly);

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        crc_hi_next = crc_hi_reg;
        rx_crc_next = rx_crc_reg;
        crc_next    = crc_reg;
        data_we     = 1'b0;
        end_hit     = 1'b0;
        if (byte_valid) begin
            case (phase_reg)
                PH_FLAG: begin
                    if (rx_byte == cfg.flag_byte) begin
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    if (rx_byte == cfg.id_byte) begin
                        crc_next   = crc_upd;
                        count_next = '0;
                        phase_next = PH_DATA;
                    end else begin
                        phase_next = PH_FLAG;
                    end
                end
                PH_DATA: begin
                    data_we  = 1'b1;
                    crc_next = crc_upd;
                    if (count_reg == DCNT_W'(DATA_LEN - 1)) begin
                        count_next  = '0;
                        crc_hi_next = 1'b0;
                        phase_next  = PH_CRC;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_CRC: begin
                    if (!crc_hi_reg) begin
                        rx_crc_next = {rx_byte, 8'h00};
                        crc_hi_next = 1'b1;
                    end else begin
                        rx_crc_next = {rx_crc_reg[15:8], rx_byte};
                        crc_hi_next = 1'b0;
                        phase_next  = PH_FLAG2;
                    end
                end
                PH_FLAG2: begin
                    phase_next = (rx_byte == cfg.flag_byte) ? PH_END : PH_FLAG;
                end
                PH_END: begin
                    phase_next = PH_FLAG;
                    end_hit    = (rx_byte == cfg.end_byte);
                end
                default: begin
                    phase_next = PH_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FLAG;
            count_reg  <= '0;
            crc_hi_reg <= 1'b0;
            rx_crc_reg <= '0;
            crc_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            crc_hi_reg <= crc_hi_next;
            rx_crc_reg <= rx_crc_next;
            crc_reg    <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_reg[count_reg] <= rx_byte;
        end
    end

    always_comb begin
        res_valid = end_hit;
        if (rx_crc_reg != crc_reg) begin
            res.outcome = OUTCOME_CRC_ERR;
        end else if ((data_reg[0] & cfg.unreliable_mask) != 8'd0) begin
            res.outcome = OUTCOME_UNRELIABLE;
        end else begin
            res.outcome = OUTCOME_GOOD;
        end
        res.status_bits    = data_reg[0];
        res.hour           = data_reg[1];
        res.minute         = data_reg[2];
        res.second_val     = data_reg[3];
        res.day_of_month   = data_reg[4];
        res.month_index    = data_reg[5] - 8'd1;
        res.year_offset    = {1'b0, data_reg[6]} + YEAR_BASE;
        res.utc_correction = {data_reg[7], data_reg[8]};
    end

endmodule

`default_nettype wire

### rtl/tcfp_out_buf.sv
`default_nettype none

module tcfp_out_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire tcfp_pkg::result_t  push_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tcfp_pkg::result_t       out_data
);
    import tcfp_pkg::*;

    result_t    slot0_reg;
    result_t    slot1_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = slot0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    slot0_reg <= push_data;
                end else begin
                    slot1_reg <= push_data;
                end
            end
            2'b01: begin
                slot0_reg <= slot1_reg;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    slot0_reg <= push_data;
                end else begin
                    slot0_reg <= slot1_reg;
                    slot1_reg <= push_data;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/time_code_frame_parser_top.sv
`default_nettype none

// Timing-frame parser: takes one received byte per transaction and hunts for
// flag, ID, nine data bytes, CRC-16 (big-endian, over ID and data), flag,
// end byte. A byte is taken in every clock cycle while s_ready is high; the
// frame state and CRC update in the cycle the byte is accepted, and a
// complete frame lands in a two-entry output buffer, so the next byte is
// taken even while a result waits on m_ready. A result is buffered on the
// end byte. Configuration writes (cfg_addr 0..5) are taken every cycle and
// act on the bytes that follow; other indexes are ignored.
module time_code_frame_parser_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tcfp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [tcfp_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_rx_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_outcome,
    output logic [7:0]                           m_status_bits,
    output logic [7:0]                           m_hour,
    output logic [7:0]                           m_minute,
    output logic [7:0]                           m_second_val,
    output logic [7:0]                           m_day_of_month,
    output logic [7:0]                           m_month_index,
    output logic [8:0]                           m_year_offset,
    output logic [15:0]                          m_utc_correction
);
    import tcfp_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    res_valid;
    logic    buf_full;
    logic    byte_acc;

    assign cfg_ready = 1'b1;
    assign s_ready   = !buf_full;
    assign byte_acc  = s_valid && s_ready;

    tcfp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .byte_valid (byte_acc),
        .rx_byte    (s_rx_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    tcfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_outcome        = out_res.outcome;
    assign m_status_bits    = out_res.status_bits;
    assign m_hour           = out_res.hour;
    assign m_minute         = out_res.minute;
    assign m_second_val     = out_res.second_val;
    assign m_day_of_month   = out_res.day_of_month;
    assign m_month_index    = out_res.month_index;
    assign m_year_offset    = out_res.year_offset;
    assign m_utc_correction = out_res.utc_correction;

endmodule

`default_nettype wire

### test/tb_time_code_frame_parser_top.sv
`default_nettype none

class TimeFrameScoreboard;
    typedef enum int {HUNT_FLAG, TAKE_ID, TAKE_DATA, TAKE_CRC, TAKE_FLAG2, TAKE_END} parse_e;

    tcfp_pkg::cfg_t    regs;
    parse_e            phase;
    int unsigned       data_idx;
    bit                crc_hi_done;
    logic [15:0]       rx_crc;
    logic [15:0]       calc_crc;
    logic [7:0]        frame_bytes[9];
    tcfp_pkg::result_t expected_frames[$];
    int unsigned       produced;
    int unsigned       errors;

    function new();
        regs.flag_byte       = 8'h7E;
        regs.id_byte         = 8'h00;
        regs.end_byte        = 8'h00;
        regs.unreliable_mask = 8'h00;
        regs.crc_poly        = 16'h1021;
        regs.crc_start       = 16'hFFFF;
        phase       = HUNT_FLAG;
        data_idx    = 0;
        crc_hi_done = 1'b0;
        rx_crc      = '0;
        calc_crc    = '0;
        foreach (frame_bytes[i]) frame_bytes[i] = '0;
        produced = 0;
        errors   = 0;
    endfunction

    // bitwise form: feedback is the register MSB xor the incoming data bit
    static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b,
                                            logic [15:0] poly);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

    function void set_reg(logic [tcfp_pkg::CFG_IDX_W-1:0] idx,
                          logic [tcfp_pkg::CFG_DAT_W-1:0] value);
        case (idx)
            tcfp_pkg::REG_FLAG_BYTE:       regs.flag_byte       = value[7:0];
            tcfp_pkg::REG_ID_BYTE:         regs.id_byte         = value[7:0];
            tcfp_pkg::REG_END_BYTE:        regs.end_byte        = value[7:0];
            tcfp_pkg::REG_UNRELIABLE_MASK: regs.unreliable_mask = value[7:0];
            tcfp_pkg::REG_CRC_POLY:        regs.crc_poly        = value;
            tcfp_pkg::REG_CRC_START:       regs.crc_start       = value;
            default: ;
        endcase
    endfunction

    // advance the frame parser by one accepted byte
    function void note_byte(logic [7:0] b);
        tcfp_pkg::result_t r;
        case (phase)
            HUNT_FLAG: begin
                if (b == regs.flag_byte) phase = TAKE_ID;
            end
            TAKE_ID: begin
                if (b == regs.id_byte) begin
                    calc_crc = crc16_step(regs.crc_start, b, regs.crc_poly);
                    data_idx = 0;
                    phase    = TAKE_DATA;
                end else begin
                    phase = HUNT_FLAG;
                end
            end
            TAKE_DATA: begin
                frame_bytes[data_idx] = b;
                calc_crc = crc16_step(calc_crc, b, regs.crc_poly);
                data_idx++;
                if (data_idx == tcfp_pkg::DATA_LEN) begin
                    data_idx    = 0;
                    crc_hi_done = 1'b0;
                    phase       = TAKE_CRC;
                end
            end
            TAKE_CRC: begin
                if (!crc_hi_done) begin
                    rx_crc      = {b, 8'h00};
                    crc_hi_done = 1'b1;
                end else begin
                    rx_crc[7:0] = b;
                    crc_hi_done = 1'b0;
                    phase       = TAKE_FLAG2;
                end
            end
            TAKE_FLAG2: begin
                phase = (b == regs.flag_byte) ? TAKE_END : HUNT_FLAG;
            end
            TAKE_END: begin
                phase = HUNT_FLAG;
                if (b == regs.end_byte) begin
                    if (rx_crc != calc_crc) begin
                        r.outcome = tcfp_pkg::OUTCOME_CRC_ERR;
                    end else if ((frame_bytes[0] & regs.unreliable_mask) != 8'h00) begin
                        r.outcome = tcfp_pkg::OUTCOME_UNRELIABLE;
                    end else begin
                        r.outcome = tcfp_pkg::OUTCOME_GOOD;
                    end
                    r.status_bits    = frame_bytes[0];
                    r.hour           = frame_bytes[1];
                    r.minute         = frame_bytes[2];
                    r.second_val     = frame_bytes[3];
                    r.day_of_month   = frame_bytes[4];
                    r.month_index    = frame_bytes[5] - 8'd1;
                    r.year_offset    = tcfp_pkg::YEAR_BASE + {1'b0, frame_bytes[6]};
                    r.utc_correction = {frame_bytes[7], frame_bytes[8]};
                    expected_frames.push_back(r);
                    produced++;
                end
            end
            default: phase = HUNT_FLAG;
        endcase
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(tcfp_pkg::result_t got);
        tcfp_pkg::result_t e;
        if (expected_frames.size() == 0) begin
            $error("unexpected result transaction: %0h", got);
            errors++;
            return;
        end
        e = expected_frames.pop_front();
        cmp_field("outcome",        16'(e.outcome),        16'(got.outcome));
        cmp_field("status_bits",    16'(e.status_bits),    16'(got.status_bits));
        cmp_field("hour",           16'(e.hour),           16'(got.hour));
        cmp_field("minute",         16'(e.minute),         16'(got.minute));
        cmp_field("second_val",     16'(e.second_val),     16'(got.second_val));
        cmp_field("day_of_month",   16'(e.day_of_month),   16'(got.day_of_month));
        cmp_field("month_index",    16'(e.month_index),    16'(got.month_index));
        cmp_field("year_offset",    16'(e.year_offset),    16'(got.year_offset));
        cmp_field("utc_correction", e.utc_correction,      got.utc_correction);
    endfunction

    function int unsigned pending();
        return expected_frames.size();
    endfunction
endclass

module tb_time_code_frame_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcfp_pkg::*;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED7 = 3'd7;

    typedef enum int {FR_GOOD, FR_BAD_CRC, FR_BAD_ID, FR_BAD_FLAG2, FR_BAD_END,
                      FR_CUT, FR_NOISE} frame_kind_e;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [1:0]           m_outcome;
    logic [7:0]           m_status_bits;
    logic [7:0]           m_hour;
    logic [7:0]           m_minute;
    logic [7:0]           m_second_val;
    logic [7:0]           m_day_of_month;
    logic [7:0]           m_month_index;
    logic [8:0]           m_year_offset;
    logic [15:0]          m_utc_correction;

    TimeFrameScoreboard sb = new();

    bit          hold_req   = 1'b0;
    int unsigned burst_left = 0;
    int unsigned max_gap    = 8;
    int unsigned bytes_sent = 0;

    time_code_frame_parser_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_outcome        (m_outcome),
        .m_status_bits    (m_status_bits),
        .m_hour           (m_hour),
        .m_minute         (m_minute),
        .m_second_val     (m_second_val),
        .m_day_of_month   (m_day_of_month),
        .m_month_index    (m_month_index),
        .m_year_offset    (m_year_offset),
        .m_utc_correction (m_utc_correction)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_outcome, m_status_bits, m_hour, m_minute, m_second_val,
                             m_day_of_month, m_month_index, m_year_offset,
                             m_utc_correction});
        end
    end

    // receiver: switches between ready patterns, plus one long hold-off on request
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = ($urandom_range(0, 3) != 0);
                    2: m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = ((tick % 7) < 3);
                endcase
            end
        end
    end

    // entered and left at a falling edge; valid drops only in gaps between bursts
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_frame(input frame_kind_e kind, input fill_e fill);
        logic [7:0]  body[9];
        logic [7:0]  seq[$];
        logic [15:0] crc;
        int unsigned n;
        if (kind == FR_NOISE) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        foreach (body[i]) begin
            case (fill)
                FILL_ZERO: body[i] = 8'h00;
                FILL_ONES: body[i] = 8'hFF;
                default:   body[i] = 8'($urandom_range(0, 255));
            endcase
        end
        if (fill == FILL_RANDOM && $urandom_range(0, 7) == 0) body[0] = 8'h00;
        crc = sb.crc16_step(sb.regs.crc_start, sb.regs.id_byte, sb.regs.crc_poly);
        foreach (body[i]) crc = sb.crc16_step(crc, body[i], sb.regs.crc_poly);
        if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
        seq.push_back(sb.regs.flag_byte);
        seq.push_back(kind == FR_BAD_ID ? sb.regs.id_byte ^ 8'($urandom_range(1, 255))
                                        : sb.regs.id_byte);
        foreach (body[i]) seq.push_back(body[i]);
        seq.push_back(crc[15:8]);
        seq.push_back(crc[7:0]);
        seq.push_back(kind == FR_BAD_FLAG2 ? sb.regs.flag_byte ^ 8'($urandom_range(1, 255))
                                           : sb.regs.flag_byte);
        seq.push_back(kind == FR_BAD_END ? sb.regs.end_byte ^ 8'($urandom_range(1, 255))
                                         : sb.regs.end_byte);
        n = (kind == FR_CUT) ? $urandom_range(1, 13) : seq.size();
        for (int i = 0; i < n; i++) send_byte(seq[i]);
    endtask

    task automatic send_random_frame();
        int unsigned r;
        int unsigned f;
        frame_kind_e kind;
        fill_e       fill;
        r = $urandom_range(0, 99);
        f = $urandom_range(0, 19);
        if (r < 60)      kind = FR_GOOD;
        else if (r < 72) kind = FR_BAD_CRC;
        else if (r < 78) kind = FR_BAD_ID;
        else if (r < 84) kind = FR_BAD_FLAG2;
        else if (r < 90) kind = FR_BAD_END;
        else if (r < 95) kind = FR_CUT;
        else             kind = FR_NOISE;
        fill = (f == 0) ? FILL_ZERO : (f == 1) ? FILL_ONES : FILL_RANDOM;
        send_frame(kind, fill);
    endtask

    // 8-bit registers get random upper data bits, which must be dropped
    task automatic load_config(input int unsigned setting);
        logic [7:0]  flag_v, id_v, end_v, mask_v;
        logic [15:0] poly_v, start_v;
        case (setting)
            0: begin
                flag_v = 8'h00; id_v = 8'h00; end_v = 8'h00; mask_v = 8'h00;
                poly_v = 16'h0000; start_v = 16'h0000;
            end
            1: begin
                flag_v = 8'hFF; id_v = 8'hFF; end_v = 8'hFF; mask_v = 8'hFF;
                poly_v = 16'hFFFF; start_v = 16'hFFFF;
            end
            2: begin
                flag_v = 8'h7E; id_v = 8'($urandom_range(0, 255));
                end_v = 8'($urandom_range(0, 255));
                mask_v = 8'h80; poly_v = 16'h1021; start_v = 16'hFFFF;
            end
            default: begin
                flag_v = 8'($urandom_range(0, 255)); id_v = 8'($urandom_range(0, 255));
                end_v = 8'($urandom_range(0, 255)); mask_v = 8'($urandom_range(0, 255));
                poly_v = 16'($urandom_range(0, 65535));
                start_v = 16'($urandom_range(0, 65535));
            end
        endcase
        cfg_write(REG_FLAG_BYTE,       {8'($urandom_range(0, 255)), flag_v});
        cfg_write(REG_ID_BYTE,         {8'($urandom_range(0, 255)), id_v});
        cfg_write(REG_END_BYTE,        {8'($urandom_range(0, 255)), end_v});
        cfg_write(REG_UNRELIABLE_MASK, {8'($urandom_range(0, 255)), mask_v});
        cfg_write(REG_CRC_POLY,        poly_v);
        cfg_write(REG_CRC_START,       start_v);
        cfg_write(REG_RESERVED6,       16'($urandom_range(0, 65535)));
        cfg_write(REG_RESERVED7,       16'($urandom_range(0, 65535)));
        cfg_valid = 1'b0;
    endtask

    initial begin
        int unsigned ph;
        int unsigned phase_start;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: all-zero frame (month wraps), flag seen where the ID
        // belongs, then an all-ones frame with a broken CRC
        send_frame(FR_GOOD, FILL_ZERO);
        send_byte(sb.regs.flag_byte);
        send_byte(sb.regs.flag_byte);
        send_frame(FR_BAD_CRC, FILL_ONES);
        wait_idle();

        ph = 0;
        while (ph < 6) begin
            load_config(ph);
            phase_start = bytes_sent;
            if (ph == 2) begin
                // stall the result side long enough to back up the input
                hold_req = 1'b1;
                max_gap  = 0;
                repeat (6) send_frame(FR_GOOD, FILL_RANDOM);
                max_gap  = 8;
            end
            while (bytes_sent - phase_start < 50) send_random_frame();
            wait_idle();
            ph++;
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
